@@ design/triangle_tone_bell_generator_assert.svh @@
// Assertion macros used by the bell generator controller
`ifndef TRIANGLE_TONE_BELL_GENERATOR_ASSERT_SVH
`define TRIANGLE_TONE_BELL_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define TTBG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttbg assertion failed");

// Next-cycle implication, checked outside reset
`define TTBG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttbg assertion failed");

`endif

@@ design/ttbg_pkg.sv @@
// Package: codes, widths and control/status types of the bell generator
`timescale 1ns / 1ps

package ttbg_pkg;

    // Field widths
    localparam int ACTION_W  = 2;
    localparam int FREQ_W    = 16;
    localparam int LEN_W     = 16;
    localparam int SR_W      = 16;
    localparam int SPT_W     = 10;
    localparam int SAMPLE_W  = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_START  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPT         = 1'd1;

    // Register reset values
    localparam logic [SR_W-1:0]  SR_RESET  = 16'd22150;
    localparam logic [SPT_W-1:0] SPT_RESET = 10'd221;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'hFF;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic div_start;
        logic div_step;
        logic commit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_done;
    } dp_status_t;

endpackage

@@ design/ttbg_if.sv @@
// Valid/ready channel interfaces for input and result words
`timescale 1ns / 1ps

interface ttbg_in_if;
    logic                           valid;
    logic                           ready;
    logic [ttbg_pkg::ACTION_W-1:0]  action;
    logic [ttbg_pkg::FREQ_W-1:0]    frequency;
    logic [ttbg_pkg::LEN_W-1:0]     length;

    modport source (output valid, output action, output frequency, output length,
                    input ready);
    modport sink   (input valid, input action, input frequency, input length,
                    output ready);
endinterface

interface ttbg_out_if;
    logic                           valid;
    logic                           ready;
    logic                           sample_valid;
    logic [ttbg_pkg::SAMPLE_W-1:0]  sample;
    logic                           ringing;
    logic                           stopped;

    modport source (output valid, output sample_valid, output sample, output ringing,
                    output stopped, input ready);
    modport sink   (input valid, input sample_valid, input sample, input ringing,
                    input stopped, output ready);
endinterface

@@ design/ttbg_datapath.sv @@
// Datapath: registers, bell state, step divider and triangle shaper
`timescale 1ns / 1ps

module ttbg_datapath #(
    parameter int PHASE_BITS    = 11,
    parameter int DURATION_BITS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ttbg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ttbg_pkg::CFG_W-1:0]         cfg_data,
    input  logic [ttbg_pkg::ACTION_W-1:0]      action,
    input  logic [ttbg_pkg::FREQ_W-1:0]        frequency,
    input  logic [ttbg_pkg::LEN_W-1:0]         length,
    input  ttbg_pkg::ctrl_cmd_t                cmd,
    output ttbg_pkg::dp_status_t               status,
    output logic                               sample_valid,
    output logic [ttbg_pkg::SAMPLE_W-1:0]      sample,
    output logic                               ringing,
    output logic                               stopped
);

    localparam int DIV_STEPS = ttbg_pkg::FREQ_W + PHASE_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int RAMP_W    = PHASE_BITS - 1 + ttbg_pkg::SAMPLE_W;

    // Configuration registers
    logic [ttbg_pkg::SR_W-1:0]  sample_rate_reg;
    logic [ttbg_pkg::SPT_W-1:0] spt_reg;

    // Latched item
    logic [ttbg_pkg::ACTION_W-1:0] action_reg;
    logic [ttbg_pkg::FREQ_W-1:0]   freq_reg;
    logic [ttbg_pkg::LEN_W-1:0]    len_reg;

    // Bell state
    logic [PHASE_BITS-1:0]         phase_reg, phase_next;
    logic [PHASE_BITS-1:0]         step_reg, step_next;
    logic [DURATION_BITS-1:0]      dur_reg, dur_next;
    logic [ttbg_pkg::SPT_W-1:0]    burst_reg, burst_next;
    logic                          active_reg, active_next;

    // Divider
    logic [DIV_STEPS-1:0]          dvd_reg;
    logic [ttbg_pkg::SR_W-1:0]     rem_reg;
    logic [PHASE_BITS-1:0]         quot_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [ttbg_pkg::SR_W:0]       rem_sh;
    logic [ttbg_pkg::SR_W:0]       rem_diff;
    logic                          q_bit;

    // Result payload
    logic                          sample_valid_reg, sample_valid_next;
    logic [ttbg_pkg::SAMPLE_W-1:0] sample_reg, sample_next;
    logic                          ringing_reg;
    logic                          stopped_reg, stopped_next;

    // Combinational helpers
    logic [DURATION_BITS:0]        dur_sum;
    logic [PHASE_BITS-1:0]         phase_sum;
    logic [RAMP_W-1:0]             ramp_wide;
    logic [ttbg_pkg::SAMPLE_W-1:0] ramp;
    logic [ttbg_pkg::SAMPLE_W-1:0] tri_val;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= ttbg_pkg::SR_RESET;
            spt_reg         <= ttbg_pkg::SPT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ttbg_pkg::CFG_SAMPLE_RATE: sample_rate_reg <= cfg_data;
                ttbg_pkg::CFG_SPT:         spt_reg <= cfg_data[ttbg_pkg::SPT_W-1:0];
                default: ;
            endcase
        end
    end

    // Item latch
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            action_reg <= action;
            freq_reg   <= frequency;
            len_reg    <= length;
        end
    end

    // Restoring divider step: one quotient bit per cycle
    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[DIV_STEPS-1]};
        rem_diff = rem_sh - {1'b0, sample_rate_reg};
        q_bit    = (rem_sh >= {1'b0, sample_rate_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.div_start)
            cnt_reg <= CNT_W'(DIV_STEPS);
        else if (cmd.div_step && cnt_reg != '0)
            cnt_reg <= cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dvd_reg  <= {freq_reg, {PHASE_BITS{1'b0}}};
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (cmd.div_step && cnt_reg != '0)
        begin
            dvd_reg  <= {dvd_reg[DIV_STEPS-2:0], 1'b0};
            rem_reg  <= q_bit ? rem_diff[ttbg_pkg::SR_W-1:0] : rem_sh[ttbg_pkg::SR_W-1:0];
            quot_reg <= {quot_reg[PHASE_BITS-2:0], q_bit};
        end
    end

    assign status.need_div = (action_reg == ttbg_pkg::ACT_START) && (dur_reg == '0);
    assign status.div_done = (cnt_reg == '0);

    // Triangle shaper on the advanced phase
    always_comb
    begin
        phase_sum = phase_reg + step_reg;
        ramp_wide = {phase_sum[PHASE_BITS-2:0], {ttbg_pkg::SAMPLE_W{1'b0}}}
                    >> (PHASE_BITS - 1);
        ramp      = ramp_wide[ttbg_pkg::SAMPLE_W-1:0];
        tri_val   = phase_sum[PHASE_BITS-1] ? (ttbg_pkg::SAMPLE_MAX - ramp) : ramp;
        dur_sum   = {1'b0, dur_reg} + (DURATION_BITS + 1)'(len_reg);
    end

    // Next bell state at commit
    always_comb
    begin
        phase_next        = phase_reg;
        step_next         = step_reg;
        dur_next          = dur_reg;
        burst_next        = burst_reg;
        active_next       = active_reg;
        sample_valid_next = 1'b0;
        sample_next       = '0;
        stopped_next      = 1'b0;
        unique case (action_reg)
            ttbg_pkg::ACT_START:
            begin
                if (dur_reg != '0)
                    dur_next = dur_sum[DURATION_BITS] ? '1 : dur_sum[DURATION_BITS-1:0];
                else
                begin
                    dur_next    = DURATION_BITS'(len_reg);
                    phase_next  = '0;
                    step_next   = (sample_rate_reg == '0) ? '0 : quot_reg;
                    active_next = 1'b1;
                end
            end
            ttbg_pkg::ACT_TICK:
            begin
                if (active_reg)
                begin
                    if (dur_reg != '0)
                    begin
                        dur_next   = dur_reg - 1'b1;
                        burst_next = spt_reg;
                    end
                    else
                    begin
                        active_next  = 1'b0;
                        burst_next   = '0;
                        stopped_next = 1'b1;
                    end
                end
            end
            ttbg_pkg::ACT_SAMPLE:
            begin
                if (burst_reg != '0)
                begin
                    burst_next        = burst_reg - 1'b1;
                    phase_next        = phase_sum;
                    sample_next       = tri_val;
                    sample_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            step_reg   <= '0;
            dur_reg    <= '0;
            burst_reg  <= '0;
            active_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            phase_reg  <= phase_next;
            step_reg   <= step_next;
            dur_reg    <= dur_next;
            burst_reg  <= burst_next;
            active_reg <= active_next;
        end
    end

    // Result word register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            sample_valid_reg <= sample_valid_next;
            sample_reg       <= sample_next;
            ringing_reg      <= active_next;
            stopped_reg      <= stopped_next;
        end
    end

    assign sample_valid = sample_valid_reg;
    assign sample       = sample_reg;
    assign ringing      = ringing_reg;
    assign stopped      = stopped_reg;

endmodule

@@ design/ttbg_ctrl.sv @@
// Controller: item sequencing, divider control and result handshake
`timescale 1ns / 1ps

`include "triangle_tone_bell_generator_assert.svh"

module ttbg_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  ttbg_pkg::dp_status_t  status,
    output ttbg_pkg::ctrl_cmd_t   cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // Command decode and next state
    always_comb
    begin
        state_next    = state_reg;
        cmd.load_item = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.commit    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (!status.div_done)
                    cmd.div_step = 1'b1;
                else if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Result valid: set on commit, cleared when taken
    assign out_valid_next = cmd.commit || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Checks
    `TTBG_ASSERT_NOW(a_commit_slot_free, clk, rst_n, cmd.commit, !out_valid_reg || out_ready)
    `TTBG_ASSERT_NEXT(a_commit_shows_word, clk, rst_n, cmd.commit, out_valid_reg)
    `TTBG_ASSERT_NEXT(a_load_to_exec, clk, rst_n, cmd.load_item, state_reg == ST_EXEC)
    `TTBG_ASSERT_NEXT(a_div_holds, clk, rst_n, state_reg == ST_DIV && !status.div_done, state_reg == ST_DIV)
    `TTBG_ASSERT_NOW(a_no_commit_mid_div, clk, rst_n, cmd.commit && state_reg == ST_DIV, status.div_done)

endmodule

@@ design/triangle_tone_bell_generator.sv @@
// Top level: triangle tone bell generator
// Sequence: a word is latched in IDLE and committed from EXEC; a start that reloads the step
//   passes EXEC, where the step divider starts, and is committed from DIV once it is done.
// Input is taken only in IDLE, so the next word waits until the last one commits; a commit
//   also waits for the result slot. The step divider makes one quotient bit per cycle.
// A waiting result word does not block acceptance of the next input word.
// Reset (rst_n, async low): bell idle, phase/step/duration/burst zero, registers at defaults.
`timescale 1ns / 1ps

module triangle_tone_bell_generator #(
    parameter int PHASE_BITS    = 11,
    parameter int DURATION_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ttbg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ttbg_pkg::CFG_W-1:0]     cfg_data,
    ttbg_in_if.sink                        item,
    ttbg_out_if.source                     result
);

    ttbg_pkg::ctrl_cmd_t  cmd;
    ttbg_pkg::dp_status_t status;
    logic                 in_ready;
    logic                 out_valid;

    ttbg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    ttbg_datapath #(
        .PHASE_BITS    (PHASE_BITS),
        .DURATION_BITS (DURATION_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (item.action),
        .frequency    (item.frequency),
        .length       (item.length),
        .cmd          (cmd),
        .status       (status),
        .sample_valid (result.sample_valid),
        .sample       (result.sample),
        .ringing      (result.ringing),
        .stopped      (result.stopped)
    );

    assign item.ready   = in_ready;
    assign result.valid = out_valid;

endmodule

@@ test/bell_tone_checker.sv @@
// Checker: predicts the bell generator's result words and compares them as they arrive
`timescale 1ns / 1ps

module bell_tone_checker
    import ttbg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    ttbg_in_if                   item,
    ttbg_out_if                  result,
    output int                   mismatch_count,
    output int                   words_due
);

    localparam int PB = 11;
    localparam int DB = 24;
    localparam logic [DB-1:0] DUR_FULL = {DB{1'b1}};

    typedef struct packed {
        logic                sample_valid;
        logic [SAMPLE_W-1:0] sample;
        logic                ringing;
        logic                stopped;
    } bell_word_t;

    // Shadow copy of the registers and the bell state
    logic [SR_W-1:0]  rate;
    logic [SPT_W-1:0] spt;
    logic [PB-1:0]    phase;
    logic [PB-1:0]    ph_step;
    logic [DB-1:0]    dur_left;
    logic [SPT_W-1:0] burst_left;
    logic             active;

    // Result words still owed by the block, oldest first
    bell_word_t bell_words_due[$];

    // Triangle byte: ramp up over the first half of the cycle, down over the second
    function automatic logic [SAMPLE_W-1:0] tri_level(input logic [PB-1:0] p);
        logic [PB+7:0] scaled;
        if (!p[PB-1])
        begin
            scaled = {p, 8'b0} >> (PB - 1);
            return scaled[7:0];
        end
        scaled = {1'b0, p[PB-2:0], 8'b0} >> (PB - 1);
        return SAMPLE_MAX - scaled[7:0];
    endfunction

    // Phase increment for a tone; wraps at the accumulator width
    function automatic logic [PB-1:0] step_for(input logic [FREQ_W-1:0] freq);
        logic [FREQ_W+PB-1:0] quot;
        if (rate == '0)
            return '0;
        quot = {freq, {PB{1'b0}}} / rate;
        return quot[PB-1:0];
    endfunction

    // Advance the bell by one input word and return the word it must produce
    function automatic bell_word_t next_bell_word(input logic [ACTION_W-1:0] act,
                                                  input logic [FREQ_W-1:0]   freq,
                                                  input logic [LEN_W-1:0]    len);
        bell_word_t w;
        logic [DB:0] sum;
        w = '0;
        case (act)
            ACT_START:
            begin
                if (dur_left != '0)
                begin
                    // still ringing with time left: lengthen only
                    sum = dur_left + len;
                    dur_left = sum[DB] ? DUR_FULL : sum[DB-1:0];
                end
                else
                begin
                    dur_left = DB'(len);
                    phase = '0;
                    ph_step = step_for(freq);
                    active = 1'b1;
                end
            end
            ACT_TICK:
            begin
                if (active)
                begin
                    if (dur_left != '0)
                    begin
                        dur_left = dur_left - 1'b1;
                        burst_left = spt;
                    end
                    else
                    begin
                        active = 1'b0;
                        burst_left = '0;
                        w.stopped = 1'b1;
                    end
                end
            end
            ACT_SAMPLE:
            begin
                if (burst_left != '0)
                begin
                    burst_left = burst_left - 1'b1;
                    phase = phase + ph_step;
                    w.sample = tri_level(phase);
                    w.sample_valid = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        w.ringing = active;
        return w;
    endfunction

    function automatic int field_diff(input string name, input int want, input int got);
        if (want == got)
            return 0;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        return 1;
    endfunction

    // Watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        bell_word_t got;
        bell_word_t want;
        int bad;
        if (!rst_n)
        begin
            rate       = SR_RESET;
            spt        = SPT_RESET;
            phase      = '0;
            ph_step    = '0;
            dur_left   = '0;
            burst_left = '0;
            active     = 1'b0;
            bell_words_due.delete();
            mismatch_count <= 0;
            words_due      <= 0;
        end
        else
        begin
            bad = 0;
            // result side first: a word pushed at this edge cannot already be answered
            if (result.valid && result.ready)
            begin
                got.sample_valid = result.sample_valid;
                got.sample       = result.sample;
                got.ringing      = result.ringing;
                got.stopped      = result.stopped;
                if (bell_words_due.size() == 0)
                begin
                    $display("%0t: result word with nothing expected: actual %0h", $time, got);
                    bad = 1;
                end
                else
                begin
                    want = bell_words_due.pop_front();
                    bad += field_diff("sample_valid", want.sample_valid, got.sample_valid);
                    bad += field_diff("sample", want.sample, got.sample);
                    bad += field_diff("ringing", want.ringing, got.ringing);
                    bad += field_diff("stopped", want.stopped, got.stopped);
                end
            end
            if (item.valid && item.ready)
                bell_words_due.push_back(next_bell_word(item.action, item.frequency,
                                                        item.length));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SAMPLE_RATE: rate = cfg_data[SR_W-1:0];
                    CFG_SPT:         spt  = cfg_data[SPT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (bad != 0)
                mismatch_count <= mismatch_count + bad;
            words_due <= bell_words_due.size();
        end
    end

endmodule

@@ test/tb_top.sv @@
// Testbench top: clock, reset, stimulus and verdict for the bell generator
`timescale 1ns / 1ps

module tb_top;
    import ttbg_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 40;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int mismatch_count;
    int words_due;
    int words_sent;
    int spt_now;
    bit steady;     // no sender gaps while set

    ttbg_in_if  item_ch();
    ttbg_out_if result_ch();

    triangle_tone_bell_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    bell_tone_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item           (item_ch),
        .result         (result_ch),
        .mismatch_count (mismatch_count),
        .words_due      (words_due)
    );

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop if the run hangs
    initial
    begin
        #10_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // Result side: stretches of ready broken by stalls, mostly short
    initial
    begin
        int run;
        int stall;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = ($urandom_range(0, 99) < 10) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            result_ch.ready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = ($urandom_range(0, 99) < 6) ? $urandom_range(10, 30) : $urandom_range(1, 3);
            result_ch.ready <= 1'b0;
            repeat (stall) @(posedge clk);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] any16();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [FREQ_W-1:0] pick_freq();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return any16();
            4, 5, 6, 7: return 16'($urandom_range(200, 5000));
            8:          return 16'hFFFF;
            default:    return 16'($urandom_range(0, 1));
        endcase
    endfunction

    // Sample slots after one tick: usually a few, now and then the whole burst and one more
    function automatic int pick_shots();
        if (spt_now <= 300 && $urandom_range(0, 29) == 0)
            return spt_now + 1;
        if (spt_now > 300 && $urandom_range(0, 79) == 0)
            return spt_now + 1;
        return $urandom_range(0, (spt_now < 6) ? spt_now + 1 : 6);
    endfunction

    // Present one word and hold it until the block takes it
    task automatic send_word(input logic [ACTION_W-1:0] act, input logic [FREQ_W-1:0] freq,
                             input logic [LEN_W-1:0] len);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.action    <= act;
        item_ch.frequency <= freq;
        item_ch.length    <= len;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Let everything drain, then write both registers
    task automatic reconfigure(input logic [CFG_W-1:0] rate, input logic [CFG_W-1:0] spt_data);
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SAMPLE_RATE;
        cfg_data  <= rate;
        @(posedge clk);
        cfg_index <= CFG_SPT;
        cfg_data  <= spt_data;
        @(posedge clk);
        cfg_we <= 1'b0;
        spt_now = int'(spt_data[SPT_W-1:0]);
    endtask

    // One whole ring: start, maybe a second start, then ticks with sample slots until it stops
    task automatic ring_sequence();
        int base_len;
        int ext_len;
        int shots;
        base_len = $urandom_range(0, 3);
        ext_len  = 0;
        steady   = ($urandom_range(0, 3) == 0);
        send_word(ACT_START, pick_freq(), LEN_W'(base_len));
        if ($urandom_range(0, 2) == 0)
        begin
            ext_len = $urandom_range(0, 2);
            send_word(ACT_START, pick_freq(), LEN_W'(ext_len));
        end
        // one tick past the end covers both extend and reload outcomes
        repeat (base_len + ext_len + 2)
        begin
            send_word(ACT_TICK, any16(), any16());
            shots = pick_shots();
            repeat (shots)
            begin
                if ($urandom_range(0, 14) == 0)
                    send_word(ACT_SPARE, any16(), any16());
                send_word(ACT_SAMPLE, any16(), any16());
            end
        end
        steady = 1'b0;
    endtask

    // Noise: any action in any order, short lengths so the bell can still end
    task automatic broken_sequence();
        logic [ACTION_W-1:0] act;
        repeat ($urandom_range(3, 12))
        begin
            act = ACTION_W'($urandom_range(0, 3));
            if (act == ACT_START)
                send_word(act, pick_freq(), LEN_W'($urandom_range(0, 3)));
            else
                send_word(act, any16(), any16());
        end
    endtask

    task automatic random_words(input int count);
        int target;
        target = words_sent + count;
        while (words_sent < target)
        begin
            if ($urandom_range(0, 6) == 0)
                broken_sequence();
            else
                ring_sequence();
        end
    endtask

    // Main stimulus
    initial
    begin
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_SAMPLE_RATE;
        cfg_data          <= '0;
        item_ch.valid     <= 1'b0;
        item_ch.action    <= ACT_START;
        item_ch.frequency <= '0;
        item_ch.length    <= '0;
        rst_n             <= 1'b0;
        words_sent = 0;
        spt_now    = int'(SPT_RESET);
        steady     = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle slots, zero-length ring, wrapped step, reload, extend, re-armed burst
        send_word(ACT_SAMPLE, 16'h0000, 16'h0000);
        send_word(ACT_TICK, 16'h0000, 16'h0000);
        send_word(ACT_SPARE, 16'hFFFF, 16'hFFFF);
        send_word(ACT_START, 16'd0, 16'd0);
        send_word(ACT_TICK, 16'd0, 16'd0);
        send_word(ACT_START, 16'hFFFF, 16'd0);
        send_word(ACT_START, 16'd1000, 16'd2);
        send_word(ACT_START, 16'd5, 16'd1);
        send_word(ACT_TICK, 16'd0, 16'd0);
        repeat (4) send_word(ACT_SAMPLE, 16'hFFFF, 16'hFFFF);
        send_word(ACT_TICK, 16'd0, 16'd0);
        repeat (3) send_word(ACT_SAMPLE, 16'd0, 16'd0);
        send_word(ACT_TICK, 16'd0, 16'd0);
        send_word(ACT_TICK, 16'd0, 16'd0);
        send_word(ACT_SAMPLE, 16'd0, 16'd0);
        send_word(ACT_TICK, 16'd0, 16'd0);
        send_word(ACT_SAMPLE, 16'd0, 16'd0);

        // Random rings under several register settings
        random_words(200);
        reconfigure(16'd4000, 16'd1);
        random_words(200);
        reconfigure(16'd48000, 16'd1023);
        random_words(200);
        reconfigure(16'd0, 16'd3);
        random_words(150);
        // upper bits of the burst write fall outside the register
        reconfigure(16'hFFFF, 16'hFC07);
        random_words(200);
        reconfigure(16'd1, 16'd2);
        random_words(150);
        reconfigure(16'($urandom_range(4000, 48000)), 16'($urandom_range(1, 40)));
        random_words(250);

        // Full-length starts drive the duration into saturation; kept last since it never drains
        reconfigure(SR_RESET, 16'd4);
        repeat (260) send_word(ACT_START, pick_freq(), 16'hFFFF);
        send_word(ACT_TICK, any16(), any16());
        repeat (5) send_word(ACT_SAMPLE, any16(), any16());
        send_word(ACT_START, pick_freq(), 16'hFFFF);
        send_word(ACT_TICK, any16(), any16());
        send_word(ACT_SAMPLE, any16(), any16());

        // Wait for the last results, then a short quiet period
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
